FILE: rtl/swb_pkg.sv
// package for the status word and mode banked register file
package swb_pkg;

  // sizes
  localparam int NUM_BANKS     = 6;
  localparam int REGS_PER_BANK = 16;
  localparam int REG_W         = $clog2(REGS_PER_BANK);
  localparam int BANK_W        = 3;
  localparam int MEM_DEPTH     = NUM_BANKS * REGS_PER_BANK;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);

  // function codes
  localparam logic [1:0] FN_WR_STATUS = 2'd0;
  localparam logic [1:0] FN_RD_STATUS = 2'd1;
  localparam logic [1:0] FN_WR_REG    = 2'd2;
  localparam logic [1:0] FN_RD_REG    = 2'd3;

  // status word masks and reset value
  localparam logic [31:0] LOW_STATUS_MASK = 32'h07FF_FFFF;
  localparam logic [31:0] FLAG_MASK       = 32'hF800_0000;
  localparam logic [31:0] MODE_MASK       = 32'h0000_001F;
  localparam logic [31:0] STATUS_RESET    = 32'h0000_001F;

  // mode codes
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h14;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // bank indexes
  localparam logic [BANK_W-1:0] BANK_USR = 3'd0;
  localparam logic [BANK_W-1:0] BANK_SVC = 3'd1;
  localparam logic [BANK_W-1:0] BANK_ABT = 3'd2;
  localparam logic [BANK_W-1:0] BANK_UND = 3'd3;
  localparam logic [BANK_W-1:0] BANK_IRQ = 3'd4;
  localparam logic [BANK_W-1:0] BANK_FIQ = 3'd5;

  // program counter register
  localparam logic [REG_W-1:0] PC_INDEX = 4'd15;

  typedef struct packed {
    logic              ok;
    logic [BANK_W-1:0] bank;
  } mode_dec_t;

  // mode field to bank
  function automatic mode_dec_t decode_mode(input logic [4:0] mode);
    mode_dec_t d;
    d.ok   = 1'b1;
    d.bank = BANK_USR;
    case (mode)
      MODE_USR, MODE_SYS: d.bank = BANK_USR;
      MODE_SVC:           d.bank = BANK_SVC;
      MODE_ABT:           d.bank = BANK_ABT;
      MODE_UND:           d.bank = BANK_UND;
      MODE_IRQ:           d.bank = BANK_IRQ;
      MODE_FIQ:           d.bank = BANK_FIQ;
      default:            d.ok   = 1'b0;
    endcase
    return d;
  endfunction

  // number of low registers shared with the other banks
  function automatic logic [REG_W-1:0] shared_count(input logic [BANK_W-1:0] bank);
    logic [REG_W-1:0] n;
    case (bank)
      BANK_USR: n = 4'd15;
      BANK_FIQ: n = 4'd8;
      default:  n = 4'd13;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/swb_in_if.sv
// request channel: function code, data, mask and register number
interface swb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] value;
  logic [31:0] mask;
  logic [3:0]  reg_index;

  modport source (output valid, output func, output value, output mask,
                  output reg_index, input ready);
  modport sink   (input valid, input func, input value, input mask,
                  input reg_index, output ready);
endinterface

FILE: rtl/swb_out_if.sv
// result channel: read data, current bank and bad mode flag
interface swb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  bank;
  logic        bad_mode;

  modport source (output valid, output read_data, output bank, output bad_mode,
                  input ready);
  modport sink   (input valid, input read_data, input bank, input bad_mode,
                  output ready);
endinterface

FILE: rtl/status_word_write_with_mode_banking.sv
// status word with mode banked register file in one memory
//
//   channel  | dir | fields                               | transfer
//   in_ch    | in  | func, value, mask, reg_index         | valid && ready
//   out_ch   | out | read_data, bank, bad_mode            | valid && ready
//
// status read, register write and status write with no bank change go to
// ST_FINISH; register read waits in ST_RDWAIT for the registered memory
// read. a bank change copies the shared registers (8 or 13) plus the pc in
// ST_COPY, one memory read and one write per cycle. reset is synchronous;
// per-entry valid bits make every register read as zero after reset. a
// result waiting on out_ch does not stop the next request from being taken.
module status_word_write_with_mode_banking (
  input  logic       clk,
  input  logic       rst_n,
  swb_in_if.sink     in_ch,
  swb_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RDWAIT = 2'd1;
  localparam logic [1:0] ST_COPY   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam int BW = swb_pkg::BANK_W;
  localparam int RW = swb_pkg::REG_W;
  localparam int AW = swb_pkg::ADDR_W;

  logic [1:0]    state_r, state_nxt;
  logic [31:0]   status_r, status_nxt;
  logic [3:0]    flags_r, flags_nxt;
  logic [BW-1:0] bank_r, bank_nxt;
  logic [BW-1:0] nb_r, nb_nxt;
  logic [RW-1:0] rd_idx_r, rd_idx_nxt;
  logic [RW-1:0] last_r, last_nxt;
  logic          rd_act_r, rd_act_nxt;
  logic [RW-1:0] wr_idx_r, wr_idx_nxt;
  logic          wr_pend_r, wr_pend_nxt;
  logic [31:0]   res_data_r, res_data_nxt;
  logic          res_bad_r, res_bad_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   out_data_r;
  logic [BW-1:0] out_bank_r;
  logic          out_bad_r;

  // register memory with registered read and per-entry valid bits
  logic [31:0]                  regs_mem [swb_pkg::MEM_DEPTH];
  logic [swb_pkg::MEM_DEPTH-1:0] vld_r;
  logic [31:0]                  mem_q_r;
  logic                         rvalid_r;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [AW-1:0]                mem_ra;
  logic [31:0]                  mem_wd;
  logic [31:0]                  rd_word;

  logic                 in_xfer;
  logic                 out_load;
  logic [31:0]          sw_new;
  logic                 mode_touch;
  swb_pkg::mode_dec_t   dec;
  logic [RW-1:0]        cnt_old;
  logic [RW-1:0]        cnt_new;
  logic [RW-1:0]        cnt_min;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);
  assign rd_word  = rvalid_r ? mem_q_r : 32'd0;

  // status write decode
  assign sw_new     = (status_r & ~in_ch.mask) | (in_ch.value & in_ch.mask);
  assign mode_touch = |(in_ch.mask & swb_pkg::MODE_MASK);
  assign dec        = swb_pkg::decode_mode(sw_new[4:0]);
  assign cnt_old    = swb_pkg::shared_count(bank_r);
  assign cnt_new    = swb_pkg::shared_count(dec.bank);
  assign cnt_min    = (cnt_old < cnt_new) ? cnt_old : cnt_new;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    flags_nxt    = flags_r;
    bank_nxt     = bank_r;
    nb_nxt       = nb_r;
    rd_idx_nxt   = rd_idx_r;
    last_nxt     = last_r;
    rd_act_nxt   = rd_act_r;
    wr_idx_nxt   = wr_idx_r;
    wr_pend_nxt  = wr_pend_r;
    res_data_nxt = res_data_r;
    res_bad_nxt  = res_bad_r;
    mem_we       = 1'b0;
    mem_wa       = {nb_r, wr_idx_r};
    mem_wd       = rd_word;
    mem_ra       = {bank_r, rd_idx_r};
    case (state_r)
      ST_IDLE: begin
        mem_ra = {bank_r, in_ch.reg_index};
        if (in_xfer) begin
          res_data_nxt = 32'd0;
          res_bad_nxt  = 1'b0;
          state_nxt    = ST_FINISH;
          case (in_ch.func)
            swb_pkg::FN_WR_STATUS: begin
              status_nxt = sw_new;
              if (|(in_ch.mask & swb_pkg::FLAG_MASK)) begin
                flags_nxt = sw_new[31:28];
              end
              res_bad_nxt = mode_touch && !dec.ok;
              if (mode_touch && dec.ok && (dec.bank != bank_r)) begin
                nb_nxt      = dec.bank;
                last_nxt    = cnt_min - 4'd1;
                rd_idx_nxt  = '0;
                rd_act_nxt  = 1'b1;
                wr_pend_nxt = 1'b0;
                state_nxt   = ST_COPY;
              end
            end
            swb_pkg::FN_RD_STATUS: begin
              res_data_nxt = {flags_r, 1'b0, status_r[26:0]};
            end
            swb_pkg::FN_WR_REG: begin
              mem_we = 1'b1;
              mem_wa = {bank_r, in_ch.reg_index};
              mem_wd = in_ch.value;
            end
            default: begin
              state_nxt = ST_RDWAIT;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        res_data_nxt = rd_word;
        state_nxt    = ST_FINISH;
      end
      ST_COPY: begin
        // read side: shared registers then the pc
        if (rd_act_r) begin
          wr_idx_nxt  = rd_idx_r;
          wr_pend_nxt = 1'b1;
          if (rd_idx_r == swb_pkg::PC_INDEX) begin
            rd_act_nxt = 1'b0;
          end else if (rd_idx_r == last_r) begin
            rd_idx_nxt = swb_pkg::PC_INDEX;
          end else begin
            rd_idx_nxt = rd_idx_r + 4'd1;
          end
        end else begin
          wr_pend_nxt = 1'b0;
        end
        // write side: follows the read in the next cycle
        if (wr_pend_r) begin
          mem_we = 1'b1;
        end
        if (!rd_act_r && wr_pend_r) begin
          bank_nxt  = nb_r;
          state_nxt = ST_FINISH;
        end
      end
      default: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      status_r    <= swb_pkg::STATUS_RESET;
      flags_r     <= 4'd0;
      bank_r      <= swb_pkg::BANK_USR;
      rd_act_r    <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      flags_r     <= flags_nxt;
      bank_r      <= bank_nxt;
      rd_act_r    <= rd_act_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      rvalid_r    <= vld_r[mem_ra];
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    nb_r       <= nb_nxt;
    rd_idx_r   <= rd_idx_nxt;
    last_r     <= last_nxt;
    wr_idx_r   <= wr_idx_nxt;
    res_data_r <= res_data_nxt;
    res_bad_r  <= res_bad_nxt;
    if (out_load) begin
      out_data_r <= res_data_r;
      out_bank_r <= bank_r;
      out_bad_r  <= res_bad_r;
    end
  end

  // memory port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      regs_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= regs_mem[mem_ra];
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.bank      = out_bank_r;
  assign out_ch.bad_mode  = out_bad_r;

  // checks
  a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
    bank_r <= swb_pkg::BANK_FIQ)
    else $error("bank index out of range");

  a_copy_banks_differ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |-> (nb_r != bank_r))
    else $error("bank copy within one bank");

  a_bank_change_from_copy: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (bank_r != $past(bank_r))) |-> ($past(state_r) == ST_COPY))
    else $error("bank changed outside a copy");

  a_status_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_ch.func == swb_pkg::FN_RD_STATUS)) |=> (state_r == ST_FINISH))
    else $error("status read did not finish next cycle");

endmodule
